[rtl/core/mfp_pkg.sv]
// ----------------------------------------------------------------------------
// mfp_pkg
// Shared constants and types of the meter frame parser: frame layout codes,
// status codes and the record that travels from the front to the back.
// ----------------------------------------------------------------------------
package mfp_pkg;

  // Field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned POS_W    = 9;
  localparam int unsigned ADDR_W   = 48;
  localparam int unsigned IDENT_W  = 16;
  localparam int unsigned STATUS_W = 3;

  // Frame layout
  localparam logic [BYTE_W-1:0] FRAME_START    = 8'h68;
  localparam logic [BYTE_W-1:0] FRAME_STOP     = 8'h16;
  localparam logic [BYTE_W-1:0] DATA_MASK      = 8'h33;
  localparam logic [POS_W-1:0]  POS_START2     = 9'd7;
  localparam logic [POS_W-1:0]  POS_CONTROL    = 9'd8;
  localparam logic [POS_W-1:0]  POS_LENGTH     = 9'd9;
  localparam logic [POS_W-1:0]  DATA_OFFSET    = 9'd10;
  localparam logic [POS_W-1:0]  POS_MAX        = 9'd511;
  localparam logic [POS_W:0]    FRAME_OVERHEAD = 10'd12;
  localparam logic [BYTE_W-1:0] MIN_FIELD_LEN  = 8'd2;
  localparam int unsigned       ADDR_BYTES     = 6;

  // Configuration reset
  localparam logic [POS_W-1:0] MIN_LEN_RESET = 9'd12;

  // Default depth of the front-to-back queue
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_NO_START = 3'd2,
    ST_BAD_LEN  = 3'd3,
    ST_NO_STOP  = 3'd4,
    ST_CHECKSUM = 3'd5
  } status_t;

  // Classified byte, as the front hands it to the back
  typedef struct packed {
    logic                has_data;
    logic [BYTE_W-1:0]   data_index;
    logic [BYTE_W-1:0]   data_byte;
    logic                is_final;
    logic                too_short;
    logic                starts_ok;
    logic                len_bad;
    logic                stop_ok;
    logic                cs_ok;
    logic [ADDR_W-1:0]   address;
    logic                response;
    logic [IDENT_W-1:0]  identifier;
    logic [BYTE_W-1:0]   payload_cnt;
  } cls_t;

  // Formatted result beat
  typedef struct packed {
    logic                has_data;
    logic [BYTE_W-1:0]   data_index;
    logic [BYTE_W-1:0]   data_byte;
    logic                is_final;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   meter_address;
    logic                response_bit;
    logic [IDENT_W-1:0]  data_identifier;
    logic [BYTE_W-1:0]   payload_length;
  } res_t;

endpackage

[rtl/core/mfp_ifs.sv]
// ----------------------------------------------------------------------------
// mfp_ifs
// Valid/ready channels of the meter frame parser: the raw byte stream in and
// the result stream out.
// ----------------------------------------------------------------------------
interface mfp_byte_if;
  logic                      valid;
  logic                      ready;
  logic [mfp_pkg::BYTE_W-1:0] rx_byte;
  logic                      end_of_buffer;

  modport source (output valid, output rx_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input rx_byte, input end_of_buffer, output ready);
endinterface

interface mfp_result_if;
  logic                        valid;
  logic                        ready;
  logic                        has_data;
  logic [mfp_pkg::BYTE_W-1:0]   data_index;
  logic [mfp_pkg::BYTE_W-1:0]   data_byte;
  logic                        is_final;
  logic [mfp_pkg::STATUS_W-1:0] status;
  logic [mfp_pkg::ADDR_W-1:0]   meter_address;
  logic                        response_bit;
  logic [mfp_pkg::IDENT_W-1:0]  data_identifier;
  logic [mfp_pkg::BYTE_W-1:0]   payload_length;

  modport source (output valid, output has_data, output data_index, output data_byte,
                  output is_final, output status, output meter_address,
                  output response_bit, output data_identifier, output payload_length,
                  input ready);
  modport sink   (input valid, input has_data, input data_index, input data_byte,
                  input is_final, input status, input meter_address,
                  input response_bit, input data_identifier, input payload_length,
                  output ready);
endinterface

[rtl/core/mfp_front.sv]
// ----------------------------------------------------------------------------
// mfp_front
// Takes one buffer byte per beat, tracks the frame position and the running
// checks, and hands a classified record to the queue for every data byte
// and for the last byte of the buffer.
// ----------------------------------------------------------------------------
module mfp_front (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         cfg_wr_en,
  input  logic [mfp_pkg::POS_W-1:0]    cfg_wr_data,
  // byte stream
  input  logic                         byte_valid,
  output logic                         byte_ready,
  input  logic [mfp_pkg::BYTE_W-1:0]   rx_byte,
  input  logic                         end_of_buffer,
  // queue side
  output logic                         push_valid,
  input  logic                         push_ready,
  output mfp_pkg::cls_t                push_data
);

  localparam int unsigned BW = mfp_pkg::BYTE_W;
  localparam int unsigned PW = mfp_pkg::POS_W;

  logic [PW-1:0]                  min_len_r;
  logic [PW-1:0]                  pos_r,    pos_nxt;
  logic [BW-1:0]                  fl_r,     fl_nxt;
  logic [BW-1:0]                  sum_r,    sum_nxt;
  logic [1:0]                     starts_r, starts_nxt;
  logic                           cs_ok_r,  cs_ok_nxt;
  logic                           stop_ok_r, stop_ok_nxt;
  logic [mfp_pkg::ADDR_W-1:0]     addr_r,   addr_nxt;
  logic                           resp_r,   resp_nxt;
  logic [mfp_pkg::IDENT_W-1:0]    ident_r,  ident_nxt;

  logic [PW-1:0]                  cs_pos;
  logic                           is_data;
  logic [BW-1:0]                  didx;
  logic [BW-1:0]                  dbyte;
  logic [PW:0]                    buf_len;
  logic [PW:0]                    frame_total;
  logic                           accept;

  assign byte_ready = push_ready;
  assign accept     = byte_valid && byte_ready;

  // Per-byte classification and state update
  always_comb begin
    fl_nxt      = (pos_r == mfp_pkg::POS_LENGTH) ? rx_byte : fl_r;
    cs_pos      = mfp_pkg::DATA_OFFSET + {1'b0, fl_nxt};
    is_data     = (pos_r >= mfp_pkg::DATA_OFFSET) && (pos_r < cs_pos);
    didx        = pos_r[BW-1:0] - mfp_pkg::DATA_OFFSET[BW-1:0];
    dbyte       = rx_byte - mfp_pkg::DATA_MASK;

    starts_nxt  = starts_r;
    if ((pos_r == '0) && (rx_byte == mfp_pkg::FRAME_START)) begin
      starts_nxt[0] = 1'b1;
    end
    if ((pos_r == mfp_pkg::POS_START2) && (rx_byte == mfp_pkg::FRAME_START)) begin
      starts_nxt[1] = 1'b1;
    end

    // address bytes sit at positions 1 to 6
    addr_nxt = addr_r;
    for (int k = 0; k < mfp_pkg::ADDR_BYTES; k++) begin
      if (pos_r == PW'(k + 1)) begin
        addr_nxt[k*BW +: BW] = addr_r[k*BW +: BW] | rx_byte;
      end
    end

    resp_nxt = (pos_r == mfp_pkg::POS_CONTROL) ? rx_byte[BW-1] : resp_r;

    // first two data bytes form the identifier
    ident_nxt = ident_r;
    if (is_data && (didx == 8'd0)) begin
      ident_nxt[BW-1:0] = dbyte;
    end else if (is_data && (didx == 8'd1)) begin
      ident_nxt[2*BW-1:BW] = dbyte;
    end

    cs_ok_nxt = cs_ok_r;
    if ((pos_r == cs_pos) && (pos_r >= mfp_pkg::DATA_OFFSET)) begin
      cs_ok_nxt = (sum_r == rx_byte);
    end
    stop_ok_nxt = stop_ok_r;
    if ((pos_r == cs_pos + 9'd1) && (pos_r > mfp_pkg::DATA_OFFSET)) begin
      stop_ok_nxt = (rx_byte == mfp_pkg::FRAME_STOP);
    end

    sum_nxt = (pos_r < cs_pos) ? (sum_r + rx_byte) : sum_r;

    pos_nxt = (pos_r < mfp_pkg::POS_MAX) ? (pos_r + 9'd1) : pos_r;

    // final checks
    buf_len     = {1'b0, pos_r} + 10'd1;
    frame_total = {2'b00, fl_nxt} + mfp_pkg::FRAME_OVERHEAD;

    push_data             = '0;
    push_data.has_data    = is_data;
    push_data.data_index  = is_data ? didx  : '0;
    push_data.data_byte   = is_data ? dbyte : '0;
    push_data.is_final    = end_of_buffer;
    push_data.too_short   = buf_len < {1'b0, min_len_r};
    push_data.starts_ok   = (starts_nxt == 2'b11);
    push_data.len_bad     = (frame_total > buf_len) || (fl_nxt < mfp_pkg::MIN_FIELD_LEN);
    push_data.stop_ok     = stop_ok_nxt;
    push_data.cs_ok       = cs_ok_nxt;
    push_data.address     = addr_nxt;
    push_data.response    = resp_nxt;
    push_data.identifier  = ident_nxt;
    push_data.payload_cnt = fl_nxt - mfp_pkg::MIN_FIELD_LEN;
  end

  assign push_valid = byte_valid && (is_data || end_of_buffer);

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= mfp_pkg::MIN_LEN_RESET;
    end else if (cfg_wr_en) begin
      min_len_r <= cfg_wr_data;
    end
  end

  // Frame state, cleared after the last byte of each buffer
  always_ff @(posedge clk) begin
    if (!rst_n || (accept && end_of_buffer)) begin
      pos_r     <= '0;
      fl_r      <= '0;
      sum_r     <= '0;
      starts_r  <= '0;
      cs_ok_r   <= 1'b0;
      stop_ok_r <= 1'b0;
      addr_r    <= '0;
      resp_r    <= 1'b0;
      ident_r   <= '0;
    end else if (accept) begin
      pos_r     <= pos_nxt;
      fl_r      <= fl_nxt;
      sum_r     <= sum_nxt;
      starts_r  <= starts_nxt;
      cs_ok_r   <= cs_ok_nxt;
      stop_ok_r <= stop_ok_nxt;
      addr_r    <= addr_nxt;
      resp_r    <= resp_nxt;
      ident_r   <= ident_nxt;
    end
  end

endmodule

[rtl/core/mfp_queue.sv]
// ----------------------------------------------------------------------------
// mfp_queue
// Short first-in first-out queue of classified records between the front
// and the back.
// ----------------------------------------------------------------------------
module mfp_queue #(
  parameter int unsigned DEPTH = mfp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  mfp_pkg::cls_t  push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output mfp_pkg::cls_t  pop_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  mfp_pkg::cls_t    slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign push_ready = (cnt_r != CNT_FULL);
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = slots[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

[rtl/core/mfp_back.sv]
// ----------------------------------------------------------------------------
// mfp_back
// Resolves the frame status in priority order, masks the fields that carry
// no meaning and holds the result beat in the output register.
// ----------------------------------------------------------------------------
module mfp_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  mfp_pkg::cls_t  pop_data,
  output logic           res_valid,
  input  logic           res_ready,
  output mfp_pkg::res_t  res_data
);

  logic            res_valid_r;
  mfp_pkg::res_t   res_data_r, res_data_nxt;
  mfp_pkg::status_t st;

  assign pop_ready = !res_valid_r || res_ready;
  assign res_valid = res_valid_r;
  assign res_data  = res_data_r;

  // Status priority: short, start, length, stop, checksum
  always_comb begin
    if (pop_data.too_short) begin
      st = mfp_pkg::ST_SHORT;
    end else if (!pop_data.starts_ok) begin
      st = mfp_pkg::ST_NO_START;
    end else if (pop_data.len_bad) begin
      st = mfp_pkg::ST_BAD_LEN;
    end else if (!pop_data.stop_ok) begin
      st = mfp_pkg::ST_NO_STOP;
    end else if (!pop_data.cs_ok) begin
      st = mfp_pkg::ST_CHECKSUM;
    end else begin
      st = mfp_pkg::ST_OK;
    end
  end

  // Result formatting
  always_comb begin
    res_data_nxt            = '0;
    res_data_nxt.has_data   = pop_data.has_data;
    res_data_nxt.data_index = pop_data.data_index;
    res_data_nxt.data_byte  = pop_data.data_byte;
    if (pop_data.is_final) begin
      res_data_nxt.is_final = 1'b1;
      res_data_nxt.status   = st;
      if (st == mfp_pkg::ST_OK) begin
        res_data_nxt.meter_address   = pop_data.address;
        res_data_nxt.response_bit    = pop_data.response;
        res_data_nxt.data_identifier = pop_data.identifier;
        res_data_nxt.payload_length  = pop_data.payload_cnt;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (pop_ready) begin
      res_valid_r <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_ready && pop_valid) begin
      res_data_r <= res_data_nxt;
    end
  end

endmodule

[rtl/core/meter_frame_parser.sv]
// ----------------------------------------------------------------------------
// meter_frame_parser
// Streaming checker and decoder for meter link frames of the form
// 68, address x6, 68, control, L, data x L, checksum, 16.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake              Beat
//  in_bus   in   valid/ready            rx_byte, end_of_buffer
//  out_bus  out  valid/ready            data byte and/or final status
//  cfg_*    in   cfg_wr_en              min_buffer_length
//
//  One byte per cycle sustained while the queue is not full.
//  The front updates the frame state in the accepting cycle; the back
//  registers the result. A queue of QUEUE_DEPTH records sits between them.
//  in_bus.ready drops only when the queue is full. Synchronous active-low
//  reset clears frame state and sets min_buffer_length to 12.
// ----------------------------------------------------------------------------
module meter_frame_parser #(
  parameter int unsigned QUEUE_DEPTH = mfp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [mfp_pkg::POS_W-1:0] cfg_wr_data,
  mfp_byte_if.sink                  in_bus,
  mfp_result_if.source              out_bus
);

  logic           push_valid, push_ready;
  mfp_pkg::cls_t  push_data;
  logic           pop_valid, pop_ready;
  mfp_pkg::cls_t  pop_data;
  logic           res_valid;
  mfp_pkg::res_t  res_data;

  // Front: position tracking and classification
  mfp_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .byte_valid    (in_bus.valid),
    .byte_ready    (in_bus.ready),
    .rx_byte       (in_bus.rx_byte),
    .end_of_buffer (in_bus.end_of_buffer),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_data     (push_data)
  );

  // Decoupling queue
  mfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back: status and output register
  mfp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .res_valid (res_valid),
    .res_ready (out_bus.ready),
    .res_data  (res_data)
  );

  // Result beat onto the channel
  assign out_bus.valid           = res_valid;
  assign out_bus.has_data        = res_data.has_data;
  assign out_bus.data_index      = res_data.data_index;
  assign out_bus.data_byte       = res_data.data_byte;
  assign out_bus.is_final        = res_data.is_final;
  assign out_bus.status          = res_data.status;
  assign out_bus.meter_address   = res_data.meter_address;
  assign out_bus.response_bit    = res_data.response_bit;
  assign out_bus.data_identifier = res_data.data_identifier;
  assign out_bus.payload_length  = res_data.payload_length;

endmodule
